// File: hdl/rrtc_pkg.sv
// Shared types, widths and constants for the RSSI rise-time classifier.
// No dependencies; used by every module of the block.
package rrtc_pkg;

    localparam int CH_W       = 2;
    localparam int RSSI_W     = 9;
    localparam int MARGIN_W   = 4;
    localparam int LIMIT_W    = 9;
    localparam int HOLD_W     = 8;
    localparam int RISE_W     = 10;
    localparam int STABLE_W   = 8;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int CMP_W      = RSSI_W + 2;

    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam int NUM_CHANNELS_DEF = 2;

    localparam logic [RISE_W-1:0]   RISE_STEP   = RISE_W'(10);
    localparam logic [RISE_W-1:0]   RISE_CAP    = RISE_W'(500);
    localparam logic [STABLE_W-1:0] STABLE_MAX  = STABLE_W'(255);
    localparam logic [RSSI_W-1:0]   LEVEL_RESET = RSSI_W'(-127);

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(3);
    localparam logic [LIMIT_W-1:0]  FAST_RESET   = LIMIT_W'(50);
    localparam logic [LIMIT_W-1:0]  NORMAL_RESET = LIMIT_W'(200);
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(3);

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NOISE  = 2'd0,
        CLASS_FAST   = 2'd1,
        CLASS_NORMAL = 2'd2,
        CLASS_SLOW   = 2'd3
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_MARGIN = 3'd0,
        REG_FAST_LIMIT  = 3'd1,
        REG_NORMAL_LIMIT = 3'd2,
        REG_NOISE_HOLD  = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [MARGIN_W-1:0] edge_margin;
        logic [LIMIT_W-1:0]  fast_limit;
        logic [LIMIT_W-1:0]  normal_limit;
        logic [HOLD_W-1:0]   noise_hold;
    } t_cfg;

    typedef struct packed {
        logic signed [RSSI_W-1:0] level;
        logic [RISE_W-1:0]        rise_time;
        logic [STABLE_W-1:0]      settle_count;
        t_class                   sig_class;
    } t_chan_state;

endpackage

// File: hdl/rrtc_cfg_regs.sv
// Configuration register file of the classifier: margin, limits, hold count.
// Depends on rrtc_pkg.
module rrtc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [rrtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rrtc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rrtc_pkg::t_cfg                   o_cfg
);

    rrtc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_margin  <= rrtc_pkg::MARGIN_RESET;
            r_cfg.fast_limit   <= rrtc_pkg::FAST_RESET;
            r_cfg.normal_limit <= rrtc_pkg::NORMAL_RESET;
            r_cfg.noise_hold   <= rrtc_pkg::HOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (rrtc_pkg::t_cfg_reg'(i_cfg_index))
                rrtc_pkg::REG_EDGE_MARGIN: begin
                    r_cfg.edge_margin <= i_cfg_data[rrtc_pkg::MARGIN_W-1:0];
                end
                rrtc_pkg::REG_FAST_LIMIT: begin
                    r_cfg.fast_limit <= i_cfg_data[rrtc_pkg::LIMIT_W-1:0];
                end
                rrtc_pkg::REG_NORMAL_LIMIT: begin
                    r_cfg.normal_limit <= i_cfg_data[rrtc_pkg::LIMIT_W-1:0];
                end
                rrtc_pkg::REG_NOISE_HOLD: begin
                    r_cfg.noise_hold <= i_cfg_data[rrtc_pkg::HOLD_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/rrtc_update.sv
// Next-state logic for one channel: rising / stable / falling decision,
// rise-time counting, classification and stable-count tracking. Depends on rrtc_pkg.
module rrtc_update (
    input  rrtc_pkg::t_cfg                    i_cfg,
    input  rrtc_pkg::t_chan_state             i_state,
    input  logic signed [rrtc_pkg::RSSI_W-1:0] i_rssi,
    output rrtc_pkg::t_chan_state             o_state
);

    logic signed [rrtc_pkg::CMP_W-1:0] x_ext;
    logic signed [rrtc_pkg::CMP_W-1:0] p_ext;
    logic signed [rrtc_pkg::CMP_W-1:0] m_ext;
    logic signed [rrtc_pkg::CMP_W-1:0] upper;
    logic signed [rrtc_pkg::CMP_W-1:0] lower;
    logic                              rising;
    logic                              stable;

    assign x_ext = rrtc_pkg::CMP_W'(i_rssi);
    assign p_ext = rrtc_pkg::CMP_W'(i_state.level);
    assign m_ext = $signed({{(rrtc_pkg::CMP_W - rrtc_pkg::MARGIN_W){1'b0}},
                            i_cfg.edge_margin});
    assign upper = p_ext + m_ext;
    assign lower = p_ext - m_ext;

    // equal to p+m is neither rising nor stable
    assign rising = x_ext > upper;
    assign stable = (x_ext > lower) && (x_ext < upper);

    always_comb begin
        o_state       = i_state;
        o_state.level = i_rssi;
        if (rising) begin
            if (i_state.rise_time == '0) begin
                o_state.rise_time = rrtc_pkg::RISE_STEP;
            end else if (i_state.rise_time < rrtc_pkg::RISE_CAP) begin
                o_state.rise_time = i_state.rise_time + rrtc_pkg::RISE_STEP;
            end
        end else if (stable) begin
            if (i_state.rise_time != '0) begin
                if (i_state.rise_time < rrtc_pkg::RISE_W'(i_cfg.fast_limit)) begin
                    o_state.sig_class = rrtc_pkg::CLASS_FAST;
                end else if (i_state.rise_time
                             < rrtc_pkg::RISE_W'(i_cfg.normal_limit)) begin
                    o_state.sig_class = rrtc_pkg::CLASS_NORMAL;
                end else begin
                    o_state.sig_class = rrtc_pkg::CLASS_SLOW;
                end
                if (i_state.settle_count < rrtc_pkg::STABLE_MAX) begin
                    o_state.settle_count = i_state.settle_count + 1'b1;
                end
            end
        end else begin
            if (i_state.settle_count < i_cfg.noise_hold) begin
                o_state.sig_class = rrtc_pkg::CLASS_NOISE;
            end
            o_state.rise_time = '0;
            if (i_state.settle_count != '0) begin
                o_state.settle_count = i_state.settle_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/rssi_rise_time_classifier.sv
// RSSI rise-time classifier: one result per sample, per-channel state in flops.
// The input register captures each sample; the state update and the result register
// then act in one step. Throughput: 1 sample per cycle while the result stream is not
// stalled, same channel back to back included. Synchronous active-low reset restores
// the register defaults and every channel to level -127 dBm, zero counts, noise.
// Depends on rrtc_pkg, rrtc_cfg_regs and rrtc_update.
module rssi_rise_time_classifier #(
    parameter int NUM_CHANNELS = rrtc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [1:0] channel, [10:2] rssi level, [15:11] zero
    input  logic [rrtc_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] signal_class, [2] channel_ignored, [7:3] zero
    output logic [rrtc_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rrtc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrtc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_CNT_W  = $clog2(NUM_CHANNELS + 1);
    localparam int CH_EXT_W  = (CH_CNT_W > rrtc_pkg::CH_W) ? CH_CNT_W : rrtc_pkg::CH_W;

    rrtc_pkg::t_cfg          cfg;
    rrtc_pkg::t_chan_state   r_state [NUM_CHANNELS];
    rrtc_pkg::t_chan_state   cur_state;
    rrtc_pkg::t_chan_state   n_state;

    logic                              r_in_valid;
    logic [rrtc_pkg::CH_W-1:0]         r_in_ch;
    logic signed [rrtc_pkg::RSSI_W-1:0] r_in_rssi;

    logic                              r_out_valid;
    rrtc_pkg::t_class                  r_out_class;
    logic                              r_out_ignored;

    logic [CH_EXT_W-1:0]               ch_ext;
    logic [CH_IDX_W-1:0]               ch_idx;
    logic                              ch_bad;
    logic                              advance;
    logic                              commit;

    rrtc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // result register frees when empty or when its transfer completes
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign commit          = r_in_valid && advance;

    assign ch_ext = CH_EXT_W'(r_in_ch);
    assign ch_idx = ch_ext[CH_IDX_W-1:0];
    assign ch_bad = ch_ext >= CH_EXT_W'(NUM_CHANNELS);

    assign cur_state = r_state[ch_idx];

    rrtc_update u_update (
        .i_cfg   (cfg),
        .i_state (cur_state),
        .i_rssi  (r_in_rssi),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_ch   <= i_s_axis_tdata[rrtc_pkg::CH_W-1:0];
            r_in_rssi <= $signed(i_s_axis_tdata[rrtc_pkg::CH_W +: rrtc_pkg::RSSI_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_state[i].level        <= rrtc_pkg::LEVEL_RESET;
                r_state[i].rise_time    <= '0;
                r_state[i].settle_count <= '0;
                r_state[i].sig_class    <= rrtc_pkg::CLASS_NOISE;
            end
        end else if (commit && !ch_bad) begin
            r_state[ch_idx] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_class   <= ch_bad ? rrtc_pkg::CLASS_NOISE : n_state.sig_class;
            r_out_ignored <= ch_bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(rrtc_pkg::M_TDATA_W - rrtc_pkg::CLASS_W - 1){1'b0}},
                              r_out_ignored, r_out_class};

endmodule
